### rtl/core/crcfe_pkg.sv
// Shared types, constants and helper functions of the CRC-framed packet encoder.
`default_nettype none

package crcfe_pkg;

	localparam int MAX_PAYLOAD_DEF = 512;
	localparam int LEN_W = 10;
	localparam int HDR_BYTES = 13;

	localparam logic [7:0] SYNC0 = 8'hAA;
	localparam logic [7:0] SYNC1 = 8'h55;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] VERSION_RST = 8'h01;

	// Kind of the byte emitted in a cycle.
	localparam logic [2:0] KIND_HDR = 3'd0;
	localparam logic [2:0] KIND_DATA = 3'd1;
	localparam logic [2:0] KIND_CRC_HI = 3'd2;
	localparam logic [2:0] KIND_CRC_LO = 3'd3;
	localparam logic [2:0] KIND_ERR = 3'd4;

	// Header byte positions.
	localparam logic [3:0] H_SYNC0 = 4'd0;
	localparam logic [3:0] H_SYNC1 = 4'd1;
	localparam logic [3:0] H_VER = 4'd2;
	localparam logic [3:0] H_TYPE = 4'd3;
	localparam logic [3:0] H_FLAGS = 4'd4;
	localparam logic [3:0] H_SEQ_HI = 4'd5;
	localparam logic [3:0] H_SEQ_LO = 4'd6;
	localparam logic [3:0] H_LEN_HI = 4'd7;
	localparam logic [3:0] H_LEN_LO = 4'd8;
	localparam logic [3:0] H_TS_3 = 4'd9;
	localparam logic [3:0] H_TS_2 = 4'd10;
	localparam logic [3:0] H_TS_1 = 4'd11;
	localparam logic [3:0] H_TS_0 = 4'd12;

	typedef struct packed {
		logic upd;
		logic clr;
		logic [7:0] data;
	} crc_ctrl_t;

	// One byte of CRC-16/CCITT-FALSE, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] hdr_byte(
		input logic [3:0] idx,
		input logic [7:0] ver,
		input logic [7:0] mtype,
		input logic [7:0] flags,
		input logic [15:0] seq,
		input logic [LEN_W-1:0] len,
		input logic [31:0] ts
	);
		logic [15:0] len16;
		logic [7:0] b;
		len16 = {{(16-LEN_W){1'b0}}, len};
		unique case (idx)
			H_SYNC0: b = SYNC0;
			H_SYNC1: b = SYNC1;
			H_VER: b = ver;
			H_TYPE: b = mtype;
			H_FLAGS: b = flags;
			H_SEQ_HI: b = seq[15:8];
			H_SEQ_LO: b = seq[7:0];
			H_LEN_HI: b = len16[15:8];
			H_LEN_LO: b = len16[7:0];
			H_TS_3: b = ts[31:24];
			H_TS_2: b = ts[23:16];
			H_TS_1: b = ts[15:8];
			H_TS_0: b = ts[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/core/crcfe_crc16.sv
// Running CRC-16/CCITT-FALSE register over the emitted frame bytes.
`default_nettype none

module crcfe_crc16 (
	input wire logic clk,
	input wire logic arst_n,
	input wire crcfe_pkg::crc_ctrl_t ctrl,
	output logic [15:0] crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= crcfe_pkg::CRC_INIT;
		end else if (ctrl.clr) begin
			crc_q <= crcfe_pkg::CRC_INIT;
		end else if (ctrl.upd) begin
			crc_q <= crcfe_pkg::crc_byte(crc_q, ctrl.data);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

### rtl/core/crc_framed_packet_encoder.sv
// A request waits in the input register; its bytes leave through the output register.
// Throughput: one byte per cycle while out_stall is low. A frame's first request emits 13
// header bytes, then its data byte or, with no payload, the two CRC bytes; a later
// request its data byte; a last request adds the CRC bytes, a length error one zero byte.
// Reset clears the input and output valids, the byte counter and bytes left,
// sets the CRC to 0xFFFF and the protocol version to 1.
`default_nettype none

module crc_framed_packet_encoder #(
	parameter int MAX_PAYLOAD = crcfe_pkg::MAX_PAYLOAD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] msg_type,
	input wire logic [7:0] msg_flags,
	input wire logic [15:0] seq_number,
	input wire logic [31:0] time_stamp,
	input wire logic [crcfe_pkg::LEN_W-1:0] payload_length,
	input wire logic [7:0] payload_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_byte,
	output logic frame_end,
	output logic length_error
);

	localparam int LW = crcfe_pkg::LEN_W;
	localparam logic [LW-1:0] MaxLen = LW'(MAX_PAYLOAD);
	localparam logic [3:0] HdrLen = 4'(crcfe_pkg::HDR_BYTES);

	logic [7:0] version_q;
	logic item_valid_s1;
	logic [7:0] msg_type_s1;
	logic [7:0] msg_flags_s1;
	logic [15:0] seq_number_s1;
	logic [31:0] time_stamp_s1;
	logic [LW-1:0] payload_length_s1;
	logic [7:0] payload_byte_s1;
	logic [3:0] pos_q;
	logic [LW-1:0] bytes_left_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic frame_end_q;
	logic length_error_q;

	logic in_acc;
	logic adv;
	logic frame_start;
	logic len_err;
	logic data_present;
	logic last_item;
	logic [3:0] rel;
	logic [2:0] kind;
	logic done;
	logic [7:0] byte_nx;
	logic [15:0] crc;
	crcfe_pkg::crc_ctrl_t crc_ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= crcfe_pkg::VERSION_RST;
		end else if (cfg_we) begin
			version_q <= cfg_wdata;
		end
	end

	assign adv = item_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = item_valid_s1 && !(adv && done);
	assign in_acc = in_valid && !in_stall;

	// The held request's place in its frame is fixed until the request is finished.
	assign frame_start = (bytes_left_q == '0);
	assign len_err = frame_start && (payload_length_s1 > MaxLen);
	assign data_present = !frame_start || (payload_length_s1 != '0);
	assign last_item = frame_start ? (payload_length_s1 <= LW'(1)) : (bytes_left_q == LW'(1));
	assign rel = frame_start ? (pos_q - HdrLen) : pos_q;

	always_comb begin
		if (len_err) begin
			kind = crcfe_pkg::KIND_ERR;
		end else if (frame_start && (pos_q < HdrLen)) begin
			kind = crcfe_pkg::KIND_HDR;
		end else if (data_present) begin
			unique case (rel)
				4'd0: kind = crcfe_pkg::KIND_DATA;
				4'd1: kind = crcfe_pkg::KIND_CRC_HI;
				default: kind = crcfe_pkg::KIND_CRC_LO;
			endcase
		end else begin
			kind = (rel == 4'd0) ? crcfe_pkg::KIND_CRC_HI : crcfe_pkg::KIND_CRC_LO;
		end
	end

	always_comb begin
		unique case (kind)
			crcfe_pkg::KIND_HDR: byte_nx = crcfe_pkg::hdr_byte(pos_q, version_q,
				msg_type_s1, msg_flags_s1, seq_number_s1, payload_length_s1,
				time_stamp_s1);
			crcfe_pkg::KIND_DATA: byte_nx = payload_byte_s1;
			crcfe_pkg::KIND_CRC_HI: byte_nx = crc[15:8];
			crcfe_pkg::KIND_CRC_LO: byte_nx = crc[7:0];
			default: byte_nx = 8'h00;
		endcase
	end

	assign done = (kind == crcfe_pkg::KIND_ERR) || (kind == crcfe_pkg::KIND_CRC_LO) ||
		((kind == crcfe_pkg::KIND_DATA) && !last_item);

	assign crc_ctrl.upd = adv && ((kind == crcfe_pkg::KIND_HDR) || (kind == crcfe_pkg::KIND_DATA));
	assign crc_ctrl.clr = adv && ((kind == crcfe_pkg::KIND_CRC_LO) ||
		(kind == crcfe_pkg::KIND_ERR));
	assign crc_ctrl.data = byte_nx;

	crcfe_crc16 u_crc (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(crc_ctrl),
		.crc(crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			pos_q <= '0;
			bytes_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				item_valid_s1 <= 1'b1;
			end else if (adv && done) begin
				item_valid_s1 <= 1'b0;
			end
			if (adv) begin
				if (done) begin
					pos_q <= '0;
					if (!frame_start) begin
						bytes_left_q <= bytes_left_q - LW'(1);
					end else if (len_err || (payload_length_s1 == '0)) begin
						bytes_left_q <= '0;
					end else begin
						bytes_left_q <= payload_length_s1 - LW'(1);
					end
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			msg_type_s1 <= msg_type;
			msg_flags_s1 <= msg_flags;
			seq_number_s1 <= seq_number;
			time_stamp_s1 <= time_stamp;
			payload_length_s1 <= payload_length;
			payload_byte_s1 <= payload_byte;
		end
		if (adv) begin
			out_byte_q <= byte_nx;
			frame_end_q <= (kind == crcfe_pkg::KIND_CRC_LO) || (kind == crcfe_pkg::KIND_ERR);
			length_error_q <= (kind == crcfe_pkg::KIND_ERR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign frame_end = frame_end_q;
	assign length_error = length_error_q;

	// An error result is a single terminating zero byte.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> frame_end && (out_byte == 8'h00))
		else $error("length error result malformed");

	// The CRC is back at its initial value once a frame or error is finished.
	a_crc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		crc_ctrl.clr |=> (crc == crcfe_pkg::CRC_INIT))
		else $error("CRC not reinitialized after frame end");

	// A finished frame leaves the block ready for a new header.
	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (kind == crcfe_pkg::KIND_CRC_LO) |=> (bytes_left_q == '0) && (pos_q == '0))
		else $error("frame end did not return to frame start");

	// The input side is never stalled while the input register is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid_s1 |-> !in_stall)
		else $error("stall while input register empty");

endmodule

`default_nettype wire

### test/crcfe_frame_checker.sv
// Checker for the CRC-framed packet encoder: predicts every output byte and compares.
`timescale 1ns / 1ps

module crcfe_frame_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [7:0] msg_type,
	input wire logic [7:0] msg_flags,
	input wire logic [15:0] seq_number,
	input wire logic [31:0] time_stamp,
	input wire logic [crcfe_pkg::LEN_W-1:0] payload_length,
	input wire logic [7:0] payload_byte,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] out_byte,
	input wire logic frame_end,
	input wire logic length_error,
	output int fail_count,
	output int pending
);

	localparam int LW = crcfe_pkg::LEN_W;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic err;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];
	logic [7:0] version;
	logic [LW-1:0] bytes_left;
	logic [15:0] frame_crc;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ crcfe_pkg::CRC_POLY) : (r << 1);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last, input logic err);
		enc_byte_t e;
		e.data = b;
		e.last = last;
		e.err = err;
		expected_bytes.insert(expected_bytes.size(), e);
	endtask

	task automatic push_data(input logic [7:0] b);
		frame_crc = crc16_next(frame_crc, b);
		queue_byte(b, 1'b0, 1'b0);
	endtask

	task automatic push_crc();
		queue_byte(frame_crc[15:8], 1'b0, 1'b0);
		queue_byte(frame_crc[7:0], 1'b1, 1'b0);
		frame_crc = crcfe_pkg::CRC_INIT;
	endtask

	// Header fields count only on the request that opens a frame.
	task automatic predict_request();
		logic [15:0] len16;
		len16 = {{(16 - LW){1'b0}}, payload_length};
		if (bytes_left == '0) begin
			frame_crc = crcfe_pkg::CRC_INIT;
			if (payload_length > crcfe_pkg::MAX_PAYLOAD_DEF) begin
				queue_byte(8'h00, 1'b1, 1'b1);
			end else begin
				push_data(crcfe_pkg::SYNC0);
				push_data(crcfe_pkg::SYNC1);
				push_data(version);
				push_data(msg_type);
				push_data(msg_flags);
				push_data(seq_number[15:8]);
				push_data(seq_number[7:0]);
				push_data(len16[15:8]);
				push_data(len16[7:0]);
				push_data(time_stamp[31:24]);
				push_data(time_stamp[23:16]);
				push_data(time_stamp[15:8]);
				push_data(time_stamp[7:0]);
				if (payload_length == '0) begin
					push_crc();
				end else begin
					push_data(payload_byte);
					bytes_left = payload_length - LW'(1);
					if (bytes_left == '0)
						push_crc();
				end
			end
		end else begin
			push_data(payload_byte);
			bytes_left = bytes_left - LW'(1);
			if (bytes_left == '0)
				push_crc();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		enc_byte_t want;
		if (!arst_n) begin
			version = crcfe_pkg::VERSION_RST;
			bytes_left = '0;
			frame_crc = crcfe_pkg::CRC_INIT;
			expected_bytes.delete();
		end else begin
			if (cfg_we)
				version = cfg_wdata;
			if (in_valid && !in_stall)
				predict_request();
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h (end %b, error %b) with none expected",
						out_byte, frame_end, length_error));
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					if (frame_end !== want.last)
						report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
							frame_end, want.last, want.data));
					if (length_error !== want.err)
						report_mismatch($sformatf("length_error %b, expected %b on byte %02h",
							length_error, want.err, want.data));
				end
			end
		end
		pending = expected_bytes.size();
	end

endmodule

### test/tb_crc_framed_packet_encoder.sv
// Testbench top for the CRC-framed packet encoder: drives requests and gives the verdict.
`timescale 1ns / 1ps

module tb_crc_framed_packet_encoder;

	localparam int LW = crcfe_pkg::LEN_W;
	localparam int PHASE_ITEMS = 15;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int TAIL_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] mtype;
		logic [7:0] flags;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [LW-1:0] len;
		logic [7:0] pbyte;
	} enc_request_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [7:0] msg_type;
	logic [7:0] msg_flags;
	logic [15:0] seq_number;
	logic [31:0] time_stamp;
	logic [LW-1:0] payload_length;
	logic [7:0] payload_byte;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic frame_end;
	logic length_error;

	int fail_count;
	int pending;
	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;

	crc_framed_packet_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.msg_type(msg_type),
		.msg_flags(msg_flags),
		.seq_number(seq_number),
		.time_stamp(time_stamp),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.length_error(length_error)
	);

	crcfe_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.msg_type(msg_type),
		.msg_flags(msg_flags),
		.seq_number(seq_number),
		.time_stamp(time_stamp),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.length_error(length_error),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, or one long hold-off when the stimulus asks for it.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic enc_request_t random_request();
		enc_request_t r;
		r.mtype = 8'($urandom());
		r.flags = 8'($urandom());
		r.seq = 16'($urandom());
		r.ts = $urandom();
		r.len = LW'($urandom());
		r.pbyte = 8'($urandom());
		return r;
	endfunction

	// Mostly short frames, with some empty ones and some over-long lengths.
	function automatic logic [LW-1:0] random_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return LW'($urandom_range(1023, crcfe_pkg::MAX_PAYLOAD_DEF + 1));
		else if (pick < 20)
			return '0;
		else if (pick < 80)
			return LW'($urandom_range(8, 1));
		else
			return LW'($urandom_range(16, 9));
	endfunction

	// Entered and left just after a falling edge.
	task automatic send_request(input enc_request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		msg_type <= r.mtype;
		msg_flags <= r.flags;
		seq_number <= r.seq;
		time_stamp <= r.ts;
		payload_length <= r.len;
		payload_byte <= r.pbyte;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Later requests of a frame carry random header fields, which the block must ignore.
	task automatic send_frame(input enc_request_t head);
		int extra;
		send_request(head);
		extra = (head.len == '0 || head.len > crcfe_pkg::MAX_PAYLOAD_DEF) ? 0 :
			int'(head.len) - 1;
		repeat (extra)
			send_request(random_request());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_version(input logic [7:0] ver);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= ver;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] ver);
		enc_request_t r;
		int first;
		set_version(ver);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			r = random_request();
			r.len = random_length();
			send_frame(r);
		end
	endtask

	initial begin : stimulus
		enc_request_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		msg_type = '0;
		msg_flags = '0;
		seq_number = '0;
		time_stamp = '0;
		payload_length = '0;
		payload_byte = '0;
		hold_req = 1'b0;
		items_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the version left at its reset value first.
		r = '0;
		send_frame(r);
		r = '1;
		r.len = '0;
		send_frame(r);
		r = random_request();
		r.len = LW'(1);
		send_frame(r);
		r = random_request();
		r.len = LW'(2);
		send_frame(r);
		r = '1;
		r.len = LW'(crcfe_pkg::MAX_PAYLOAD_DEF + 1);
		send_frame(r);
		r = '1;
		send_frame(r);
		r = random_request();
		r.len = LW'(1);
		r.pbyte = 8'h00;
		send_frame(r);
		r = random_request();
		r.len = LW'(1);
		r.pbyte = 8'hFF;
		send_frame(r);
		set_version(8'h00);
		r = random_request();
		r.len = '0;
		send_frame(r);
		set_version(8'hFF);
		r = random_request();
		r.len = LW'(3);
		send_frame(r);
		r = random_request();
		r.len = LW'(1023);
		send_frame(r);

		run_phase(0, 0, 8'($urandom()));
		// The output is held off while requests keep coming, so the block has to stall them.
		hold_req = 1'b1;
		r = random_request();
		r.len = LW'(12);
		send_frame(r);

		run_phase(67, 0, 8'($urandom()));
		run_phase(0, 67, 8'h00);
		run_phase(32, 32, 8'hFF);

		wait_drained();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
